@@ design/mqrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Multi-queue ring FIFO package
// Field widths, operation and status codes, and the type of the request
// that sits between the storage read and the response register.
// ----------------------------------------------------------------------------
package mqrf_pkg;

   localparam int DATA_W       = 32;
   localparam int MODE_W       = 2;
   localparam int QINDEX_W     = 2;
   localparam int STATUS_W     = 2;
   localparam int FILL_LEVEL_W = 5;
   localparam int LOST_W       = 32;

   // Operation codes carried in req_mode.
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Status codes returned in rsp_status.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // Result of one request, waiting for the word that the storage returns.
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [FILL_LEVEL_W-1:0] fill_level;
      logic [LOST_W-1:0]       lost_count;
      logic                    use_ram;
   } pend_type;

endpackage

@@ design/mqrf_ram.sv @@
// ----------------------------------------------------------------------------
// Multi-queue ring FIFO word storage
// Generic simple dual-port RAM with one write port and one registered read
// port. The read data holds its value while no read is issued.
// ----------------------------------------------------------------------------
module mqrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/multi_queue_ring_fifo_top.sv @@
// ----------------------------------------------------------------------------
// Multi-queue ring FIFO
// A bank of QUEUE_COUNT ring-buffer FIFOs of 32-bit words that share one
// word storage. Each request reads, writes or clears one queue.
//
// Usage: a request (req_mode, req_queue_index, req_write_data) is taken at
// a rising edge where req_valid is high and req_stall is low. Every request
// produces exactly one response (rsp_read_data, rsp_status, rsp_fill_level,
// rsp_lost_count), taken at an edge where rsp_valid is high and rsp_stall is
// low. A read pops the oldest word or reports an empty queue; a write to a
// full queue drops the oldest word, keeps the new one and counts a lost
// word; a clear empties the queue and zeroes its lost-word counter.
// A request passes through the middle stage, where the registered storage
// read completes, and then into the response register that drives
// rsp_valid. Throughput is one request per cycle while the receiver does
// not stall, since each request touches one queue and makes at most one
// storage access. When the receiver stalls, the response register holds
// and one more request may still be taken into the middle stage; after that
// req_stall rises until the response is taken. Reset (synchronous) empties
// every queue and zeroes all lost-word counters at once; the storage itself
// is not cleared and needs no clearing pass, since a word is only read after
// it was written.
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int QUEUE_COUNT = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mqrf_pkg::MODE_W-1:0]        req_mode,
   input  logic [mqrf_pkg::QINDEX_W-1:0]      req_queue_index,
   input  logic [mqrf_pkg::DATA_W-1:0]        req_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mqrf_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [mqrf_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mqrf_pkg::FILL_LEVEL_W-1:0]  rsp_fill_level,
   output logic [mqrf_pkg::LOST_W-1:0]        rsp_lost_count
);

   // Widths derived from the queue geometry.
   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int QIDX_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int WORDS    = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int ADDR_W   = $clog2(WORDS);

   // Per-queue control state, all in flip-flops.
   logic [PTR_W-1:0]                  rd_ptr_ff  [QUEUE_COUNT];
   logic [PTR_W-1:0]                  wr_ptr_ff  [QUEUE_COUNT];
   logic [FILL_W-1:0]                 fill_ff    [QUEUE_COUNT];
   logic [mqrf_pkg::LOST_W-1:0]       lost_ff    [QUEUE_COUNT];

   // Middle stage: result of the request, waiting for the storage word.
   logic                              pend_valid_ff;
   logic                              pend_valid_in;
   mqrf_pkg::pend_type                pend_ff;
   mqrf_pkg::pend_type                pend_in;

   // Response register.
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [mqrf_pkg::DATA_W-1:0]       rsp_read_data_ff;
   logic [mqrf_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [mqrf_pkg::FILL_LEVEL_W-1:0] rsp_fill_level_ff;
   logic [mqrf_pkg::LOST_W-1:0]       rsp_lost_count_ff;

   // Handshake.
   logic                              out_free;
   logic                              pend_move;
   logic                              accept;

   // Request decode and next queue state.
   logic                              in_range;
   logic [QIDX_W-1:0]                 q_idx;
   logic [PTR_W-1:0]                  cur_rd;
   logic [PTR_W-1:0]                  cur_wr;
   logic [FILL_W-1:0]                 cur_fill;
   logic [mqrf_pkg::LOST_W-1:0]       cur_lost;
   logic [PTR_W-1:0]                  new_rd;
   logic [PTR_W-1:0]                  new_wr;
   logic [FILL_W-1:0]                 new_fill;
   logic [mqrf_pkg::LOST_W-1:0]       new_lost;
   logic [mqrf_pkg::STATUS_W-1:0]     op_status;
   logic                              op_read;
   logic                              op_write;
   logic [ADDR_W-1:0]                 base_addr;
   logic [ADDR_W-1:0]                 ram_addr;
   logic                              ram_rd_en;
   logic                              ram_wr_en;
   logic [mqrf_pkg::DATA_W-1:0]       ram_rd_data;

   // Advance a slot number around the ring.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // The middle stage may move on whenever the response register is empty
   // or being taken in this cycle; a new request is taken whenever the middle
   // stage is empty or moving on.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pend_move = pend_valid_ff && out_free;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Queue selection. Indexes beyond the bank give an all-zero response and
   // leave every queue alone.
   assign in_range  = 32'(req_queue_index) < 32'(QUEUE_COUNT);
   assign q_idx     = QIDX_W'(req_queue_index);
   assign cur_rd    = rd_ptr_ff[q_idx];
   assign cur_wr    = wr_ptr_ff[q_idx];
   assign cur_fill  = fill_ff[q_idx];
   assign cur_lost  = lost_ff[q_idx];
   assign base_addr = ADDR_W'(q_idx) * ADDR_W'(QUEUE_DEPTH);

   always_comb begin
      new_rd    = cur_rd;
      new_wr    = cur_wr;
      new_fill  = cur_fill;
      new_lost  = cur_lost;
      op_status = mqrf_pkg::ST_OK;
      op_read   = 1'b0;
      op_write  = 1'b0;
      case (req_mode)
         mqrf_pkg::MODE_READ: begin
            if (cur_fill == '0) begin
               op_status = mqrf_pkg::ST_EMPTY;
            end else begin
               op_read  = 1'b1;
               new_rd   = next_slot(cur_rd);
               new_fill = cur_fill - 1'b1;
            end
         end
         mqrf_pkg::MODE_WRITE: begin
            op_write = 1'b1;
            new_wr   = next_slot(cur_wr);
            if (cur_fill == FILL_W'(QUEUE_DEPTH)) begin
               // Full: the oldest word is overwritten, so head moves too.
               new_rd    = next_slot(cur_rd);
               new_lost  = cur_lost + 1'b1;
               op_status = mqrf_pkg::ST_OVERFLOW;
            end else begin
               new_fill = cur_fill + 1'b1;
            end
         end
         mqrf_pkg::MODE_CLEAR: begin
            new_rd   = '0;
            new_wr   = '0;
            new_fill = '0;
            new_lost = '0;
         end
         default: begin
            // Unused code: no operation, the queue is reported unchanged.
         end
      endcase
   end

   assign ram_rd_en = accept && in_range && op_read;
   assign ram_wr_en = accept && in_range && op_write;
   assign ram_addr  = base_addr + ADDR_W'(op_write ? cur_wr : cur_rd);

   always_comb begin
      pend_in.status     = in_range ? op_status : mqrf_pkg::ST_OK;
      pend_in.fill_level = in_range ? mqrf_pkg::FILL_LEVEL_W'(new_fill) : '0;
      pend_in.lost_count = in_range ? new_lost : '0;
      pend_in.use_ram    = in_range && op_read;
   end

   assign pend_valid_in = accept || (pend_valid_ff && !pend_move);
   assign rsp_valid_in  = pend_move || (rsp_valid_ff && !out_free);

   mqrf_ram #(
      .WIDTH (mqrf_pkg::DATA_W),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (req_write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Per-queue state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            fill_ff[i]   <= '0;
            lost_ff[i]   <= '0;
         end
      end else if (accept && in_range) begin
         rd_ptr_ff[q_idx] <= new_rd;
         wr_ptr_ff[q_idx] <= new_wr;
         fill_ff[q_idx]   <= new_fill;
         lost_ff[q_idx]   <= new_lost;
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Stage payloads. The storage word is valid while the request sits in the
   // middle stage, because no other read is issued until it moves on.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_move) begin
         rsp_read_data_ff  <= pend_ff.use_ram ? ram_rd_data : '0;
         rsp_status_ff     <= pend_ff.status;
         rsp_fill_level_ff <= pend_ff.fill_level;
         rsp_lost_count_ff <= pend_ff.lost_count;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_level = rsp_fill_level_ff;
   assign rsp_lost_count = rsp_lost_count_ff;

   // A read of an empty queue must come out as an empty status.
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      accept && in_range && (req_mode == mqrf_pkg::MODE_READ) && (cur_fill == '0)
      |=> pend_valid_ff && (pend_ff.status == mqrf_pkg::ST_EMPTY) && !pend_ff.use_ram)
      else $error("empty read did not report empty status");

   // A popped word always goes with an ok status.
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && pend_ff.use_ram |-> (pend_ff.status == mqrf_pkg::ST_OK))
      else $error("popped word with non-ok status");

   // Requests are held back only when both stages are occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pend_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free stage");

   // No queue ever holds more words than its depth.
   for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_fill_chk
      a_fill_bound: assert property (@(posedge clock) disable iff (reset)
         fill_ff[g] <= FILL_W'(QUEUE_DEPTH))
         else $error("queue fill count above depth");
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-queue ring FIFO testbench
// Sends directed and then random read, write, clear and no-op requests to the
// block. Random gaps on the request side and random stalls on the response
// side are inserted outside one quiet stretch. A scoreboard keeps its own copy of the queue
// bank and compares every response with the one predicted for the oldest
// outstanding request.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_COUNT = 4;
   localparam int RANDOM_REQUESTS = 1550;

   // Mode value three has no operation behind it; the block reports the
   // addressed queue without touching it.
   localparam logic [mqrf_pkg::MODE_W-1:0] MODE_NOP = 2'd3;

   // One response as it appears on the rsp_ ports.
   typedef struct packed {
      logic [mqrf_pkg::DATA_W-1:0]       read_data;
      logic [mqrf_pkg::STATUS_W-1:0]     status;
      logic [mqrf_pkg::FILL_LEVEL_W-1:0] fill_level;
      logic [mqrf_pkg::LOST_W-1:0]       lost_count;
   } rsp_fields_type;

   // The scoreboard holds a shadow of every queue: its stored words, the
   // slot of the oldest word, the slot for the next write, the number of
   // words held and the lost-word counter. Each accepted request updates
   // the shadow and leaves the response it should produce in a queue.
   class fifo_bank_scoreboard_type;
      logic [mqrf_pkg::DATA_W-1:0] stored_words [QUEUE_COUNT][QUEUE_DEPTH];
      int                          oldest_slot  [QUEUE_COUNT];
      int                          next_slot    [QUEUE_COUNT];
      int                          held_words   [QUEUE_COUNT];
      logic [mqrf_pkg::LOST_W-1:0] dropped_words[QUEUE_COUNT];
      rsp_fields_type              expected_rsp [$];
      int                          failures;

      function new();
         failures = 0;
         for (int q = 0; q < QUEUE_COUNT; q++) begin
            oldest_slot[q]   = 0;
            next_slot[q]     = 0;
            held_words[q]    = 0;
            dropped_words[q] = '0;
         end
      endfunction

      function void note_request(logic [mqrf_pkg::MODE_W-1:0] mode,
                                 logic [mqrf_pkg::QINDEX_W-1:0] q,
                                 logic [mqrf_pkg::DATA_W-1:0] data);
         rsp_fields_type want;
         want = '0;
         if (q < QUEUE_COUNT) begin
            case (mode)
               mqrf_pkg::MODE_READ: begin
                  if (held_words[q] == 0) begin
                     want.status = mqrf_pkg::ST_EMPTY;
                  end else begin
                     want.read_data = stored_words[q][oldest_slot[q]];
                     oldest_slot[q] = (oldest_slot[q] + 1) % QUEUE_DEPTH;
                     held_words[q]--;
                  end
               end
               mqrf_pkg::MODE_WRITE: begin
                  stored_words[q][next_slot[q]] = data;
                  next_slot[q] = (next_slot[q] + 1) % QUEUE_DEPTH;
                  if (held_words[q] >= QUEUE_DEPTH) begin
                     // Full queue: the oldest word is dropped to make room.
                     oldest_slot[q]   = (oldest_slot[q] + 1) % QUEUE_DEPTH;
                     dropped_words[q] = dropped_words[q] + 1'b1;
                     want.status      = mqrf_pkg::ST_OVERFLOW;
                  end else begin
                     held_words[q]++;
                  end
               end
               mqrf_pkg::MODE_CLEAR: begin
                  oldest_slot[q]   = 0;
                  next_slot[q]     = 0;
                  held_words[q]    = 0;
                  dropped_words[q] = '0;
               end
               default: ;
            endcase
            want.fill_level = held_words[q][mqrf_pkg::FILL_LEVEL_W-1:0];
            want.lost_count = dropped_words[q];
         end
         expected_rsp.push_back(want);
      endfunction

      function void check_response(rsp_fields_type got);
         rsp_fields_type want;
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding: data %h status %0d",
                   got.read_data, got.status);
            failures++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.read_data !== want.read_data) begin
            $error("rsp_read_data: expected %h, got %h", want.read_data, got.read_data);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, got.status);
            failures++;
         end
         if (got.fill_level !== want.fill_level) begin
            $error("rsp_fill_level: expected %0d, got %0d", want.fill_level,
                   got.fill_level);
            failures++;
         end
         if (got.lost_count !== want.lost_count) begin
            $error("rsp_lost_count: expected %0d, got %0d", want.lost_count,
                   got.lost_count);
            failures++;
         end
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [mqrf_pkg::MODE_W-1:0]       req_mode = mqrf_pkg::MODE_READ;
   logic [mqrf_pkg::QINDEX_W-1:0]     req_queue_index = '0;
   logic [mqrf_pkg::DATA_W-1:0]       req_write_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [mqrf_pkg::DATA_W-1:0]       rsp_read_data;
   logic [mqrf_pkg::STATUS_W-1:0]     rsp_status;
   logic [mqrf_pkg::FILL_LEVEL_W-1:0] rsp_fill_level;
   logic [mqrf_pkg::LOST_W-1:0]       rsp_lost_count;

   // While this is set, neither side inserts gaps or stalls, so the block
   // also runs for a long stretch at its full rate.
   bit                                quiet_stretch = 1'b0;
   int                                random_sent = 0;

   fifo_bank_scoreboard_type          fifo_model = new();

   multi_queue_ring_fifo_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .QUEUE_COUNT(QUEUE_COUNT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_queue_index(req_queue_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .rsp_fill_level (rsp_fill_level),
      .rsp_lost_count (rsp_lost_count)
   );

   always #2 clock = ~clock;

   // The receiver stalls at random, with a chance of eleven in a hundred, except
   // during the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_stretch && ($urandom_range(0, 99) < 11);
      end
   end

   // Responses are sampled at the edge, so the values seen are the ones
   // that stood during the cycle in which the handshake completed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         fifo_model.check_response({rsp_read_data, rsp_status, rsp_fill_level,
                                    rsp_lost_count});
      end
   end

   // Presents one request and returns at the edge where it was taken. Before
   // the request, the sender may at random hold req_valid low to leave a gap. The caller's next
   // request raises req_valid again in the same time step, so it is never
   // lowered and raised within one step.
   task automatic issue_request(logic [mqrf_pkg::MODE_W-1:0] mode,
                                logic [mqrf_pkg::QINDEX_W-1:0] q,
                                logic [mqrf_pkg::DATA_W-1:0] data);
      if (!quiet_stretch && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_queue_index <= q;
      req_write_data  <= data;
      do @(posedge clock); while (req_stall);
      fifo_model.note_request(mode, q, data);
   endtask

   // Most write data is random; now and then an all-zeros or all-ones word
   // is used so that the extremes also pass through the storage.
   function automatic logic [mqrf_pkg::DATA_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Random requests mostly come in bursts aimed at one queue, so that queues
   // are filled past the brim and drained past empty, with mixed and clearing
   // bursts and bursts spread over all queues in between.
   task automatic run_random_bursts();
      logic [mqrf_pkg::QINDEX_W-1:0] q;
      int                            kind;
      int                            burst;
      while (random_sent < RANDOM_REQUESTS) begin
         quiet_stretch = (random_sent >= 600) && (random_sent < 900);
         q     = mqrf_pkg::QINDEX_W'($urandom_range(0, QUEUE_COUNT - 1));
         kind  = $urandom_range(0, 99);
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) begin
            if (kind < 35) begin
               issue_request(mqrf_pkg::MODE_WRITE, q, pick_word());
            end else if (kind < 62) begin
               issue_request(mqrf_pkg::MODE_READ, q, pick_word());
            end else if (kind < 80) begin
               // Any mode, including the unused one, on the same queue.
               issue_request(mqrf_pkg::MODE_W'($urandom_range(0, 3)), q, pick_word());
            end else if (kind < 85) begin
               issue_request(mqrf_pkg::MODE_CLEAR, q, pick_word());
               i = burst;
            end else begin
               // Interleaved reads and writes spread over all queues.
               issue_request($urandom_range(0, 1) ? mqrf_pkg::MODE_WRITE
                                                  : mqrf_pkg::MODE_READ,
                             mqrf_pkg::QINDEX_W'($urandom_range(0, QUEUE_COUNT - 1)),
                             pick_word());
            end
            random_sent++;
         end
      end
      quiet_stretch = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reads of every queue while all are empty.
      for (int q = 0; q < QUEUE_COUNT; q++) begin
         issue_request(mqrf_pkg::MODE_READ, mqrf_pkg::QINDEX_W'(q), '1);
      end
      // Extreme words in and out of one queue, then one read too many.
      issue_request(mqrf_pkg::MODE_WRITE, 2'd0, 32'h0000_0000);
      issue_request(mqrf_pkg::MODE_WRITE, 2'd0, 32'hFFFF_FFFF);
      issue_request(mqrf_pkg::MODE_WRITE, 2'd1, 32'hA5A5_A5A5);
      issue_request(mqrf_pkg::MODE_WRITE, 2'd3, 32'h5A5A_5A5A);
      issue_request(mqrf_pkg::MODE_READ,  2'd0, '0);
      issue_request(mqrf_pkg::MODE_READ,  2'd0, '0);
      issue_request(mqrf_pkg::MODE_READ,  2'd0, '0);
      // The unused mode leaves the queue as it was.
      issue_request(MODE_NOP,             2'd1, '1);
      issue_request(MODE_NOP,             2'd2, '0);
      // Clearing a queue that holds a word, then reading it.
      issue_request(mqrf_pkg::MODE_CLEAR, 2'd1, '0);
      issue_request(mqrf_pkg::MODE_READ,  2'd1, '0);
      issue_request(mqrf_pkg::MODE_CLEAR, 2'd2, '1);
      issue_request(mqrf_pkg::MODE_WRITE, 2'd2, 32'h1234_5678);
      issue_request(mqrf_pkg::MODE_READ,  2'd2, '0);
      issue_request(mqrf_pkg::MODE_READ,  2'd3, '0);

      run_random_bursts();
      req_valid <= 1'b0;

      // Wait for every response, then keep the clock running so that a stray
      // extra response would still be caught.
      while (fifo_model.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fifo_model.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // A hung handshake ends the run here.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
